@@ hdl/sgp_pkg.sv @@
`timescale 1ns / 1ps

package sgp_pkg;

    // Field and register widths
    localparam int POS_W      = 32;
    localparam int VAL_W      = 24;
    localparam int FRAC_W     = 8;
    localparam int GAIN_W     = 32;
    localparam int SHORT_W    = 16;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Stream packing
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 88;
    localparam int OUT_USED_W = POS_W + 1 + SHORT_W + POS_W;

    // Arithmetic widths
    localparam int DIFF_W    = VAL_W + 1;
    localparam int MUL_A_W   = GAIN_W + 1;
    localparam int PROD_W    = MUL_A_W + DIFF_W;
    localparam int PROD_FRAC = 16 + FRAC_W;
    localparam int RND_W     = PROD_W - PROD_FRAC;
    localparam int WIDE_W    = RND_W + 1;
    localparam int CNT_W     = $clog2(POS_W);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (PROD_FRAC - 1);
    localparam logic signed [WIDE_W-1:0] POS_MAX_W  = (WIDE_W'(1) <<< (POS_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] POS_MIN_W  = -(WIDE_W'(1) <<< (POS_W - 1));

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET_VALUE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_POS  = 2'd1;
    localparam logic [OP_W-1:0] OP_NUDGE     = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_STEPS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_UNIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SPAN   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CIRCULAR       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BACKLASH       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY     = 3'd7;

    // Register reset values
    localparam logic [GAIN_W-1:0]  RST_ZERO_STEPS     = 32'd0;
    localparam logic [GAIN_W-1:0]  RST_STEPS_PER_UNIT = 32'd65536;
    localparam logic [VAL_W-1:0]   RST_MIN_VALUE      = 24'd0;
    localparam logic [VAL_W-1:0]   RST_MAX_VALUE      = 24'd92160;
    localparam logic [SHORT_W-1:0] RST_DEFAULT_SPAN   = 16'd2048;
    localparam logic [SHORT_W-1:0] RST_STEP_DELAY     = 16'd3;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL_T,
        ST_SUM_T,
        ST_RND_T,
        ST_MUL_S,
        ST_SUM_S,
        ST_RND_S,
        ST_REM_C,
        ST_REM_CW,
        ST_REM_T,
        ST_REM_TW,
        ST_WRAP,
        ST_WRAP2,
        ST_PLAN,
        ST_NUDGE,
        ST_LEG1,
        ST_LEG2,
        ST_COILS
    } sgp_state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic take_in;
        logic span_sel;
        logic mul_en;
        logic sum_en;
        logic rnd_en;
        logic rem_start;
        logic rem_sel;
        logic cm_load;
        logic tm_load;
        logic wrap_en;
        logic wrap2_en;
        logic load_pos;
        logic nudge_en;
        logic plan_en;
        logic leg_emit;
        logic leg_to_target;
        logic coils_emit;
    } sgp_cmd_t;

    // Status from the datapath to the sequencer
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            circular;
        logic            backlash_nz;
        logic            steps_zero;
        logic            target_eq_needle;
        logic            leg_zero;
        logic            out_free;
        logic            rem_done;
    } sgp_status_t;

    // Round a product with PROD_FRAC fraction bits half away from zero
    function automatic logic signed [RND_W-1:0] round_q(input logic signed [PROD_W-1:0] x);
        logic signed [PROD_W-1:0] t;
        t = x + ROUND_HALF - {{(PROD_W-1){1'b0}}, x[PROD_W-1]};
        return RND_W'(t >>> PROD_FRAC);
    endfunction

    // Saturate a wide signed value to the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [WIDE_W-1:0] x);
        logic signed [POS_W-1:0] r;
        if (x > POS_MAX_W)
            r = POS_MAX_W[POS_W-1:0];
        else if (x < POS_MIN_W)
            r = POS_MIN_W[POS_W-1:0];
        else
            r = x[POS_W-1:0];
        return r;
    endfunction

endpackage

@@ hdl/stepper_gauge_positioner_unit.sv @@
`timescale 1ns / 1ps
// Channel   Ports                                 Contents
// input     s_tvalid s_tready s_tdata s_tuser     value, steps; operation in tuser
// output    m_tvalid m_tready m_tdata m_tuser     leg or coils-off result, last in tlast
// config    cfg_we cfg_index cfg_data             one register write per cycle
//
// One input transaction is worked on at a time. A circular set value makes two
// bit-serial remainder passes through the shared remainder unit.
// Reset clears the needle position and restores the register defaults at once.
// A stalled output holds the sequencer in its emit state; the last result waits
// in the output register while the next input transaction is taken.

module stepper_gauge_positioner_unit
    import sgp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // value [23:0], steps [55:24]
    input  logic [OP_W-1:0]       s_tuser,   // operation [1:0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // step_count [31:0], direction [32],
                                             // leg_delay [48:33], new_position [80:49]
    output logic                  m_tuser,   // coils_off [0]
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    sgp_cmd_t    cmd;
    sgp_status_t sts;

    // Sequencer
    sgp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Arithmetic, position tracking and output register
    sgp_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule

@@ hdl/sgp_rem.sv @@
`timescale 1ns / 1ps

module sgp_rem
    import sgp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [POS_W-1:0] dividend,
    input  logic [POS_W-1:0] divisor,
    output logic             busy,
    output logic [POS_W-1:0] remainder
);

    logic             busy_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [POS_W-1:0] quo_reg;
    logic [POS_W-1:0] div_reg;
    logic [POS_W-1:0] rem_reg;
    logic [POS_W:0]   rem_sh;
    logic             rem_ge;

    // One restoring step: shift in the next dividend bit and subtract if it fits
    assign rem_sh = {rem_reg, quo_reg[POS_W-1]};
    assign rem_ge = rem_sh >= {1'b0, div_reg};

    // Control: one bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(POS_W - 1);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    // Partial remainder and shifting dividend
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            div_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[POS_W-2:0], 1'b0};
            if (rem_ge)
                rem_reg <= POS_W'(rem_sh - {1'b0, div_reg});
            else
                rem_reg <= rem_sh[POS_W-1:0];
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

@@ hdl/sgp_datapath.sv @@
`timescale 1ns / 1ps

module sgp_datapath
    import sgp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sgp_cmd_t              cmd,
    output sgp_status_t           sts,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [OP_W-1:0]       s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // Configuration registers
    logic signed [GAIN_W-1:0] zero_steps_reg;
    logic signed [GAIN_W-1:0] steps_per_unit_reg;
    logic signed [VAL_W-1:0]  min_value_reg;
    logic signed [VAL_W-1:0]  max_value_reg;
    logic [SHORT_W-1:0]       default_span_reg;
    logic                     circular_reg;
    logic [SHORT_W-1:0]       backlash_reg;
    logic [SHORT_W-1:0]       step_delay_reg;

    // Latched input transaction
    logic [OP_W-1:0]          op_reg;
    logic signed [VAL_W-1:0]  value_reg;
    logic signed [POS_W-1:0]  steps_reg;

    // Working registers
    logic signed [POS_W-1:0]  needle_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [POS_W-1:0]  target_reg;
    logic [POS_W-1:0]         span_reg;
    logic [POS_W-1:0]         cm_reg;
    logic [POS_W-1:0]         tm_reg;
    logic signed [POS_W+1:0]  dist_reg;
    logic signed [POS_W-1:0]  leg_to_reg;

    // Output register
    logic                     out_valid_reg;
    logic [POS_W-1:0]         out_count_reg;
    logic                     out_dir_reg;
    logic [SHORT_W-1:0]       out_delay_reg;
    logic                     out_coils_reg;
    logic signed [POS_W-1:0]  out_pos_reg;
    logic                     out_last_reg;

    // Combinational intermediates
    logic signed [MUL_A_W-1:0] spu_ext;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [DIFF_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [PROD_W-1:0]  zero_sh;
    logic signed [RND_W-1:0]   rnd_val;
    logic [POS_W-1:0]          dflt_span;
    logic signed [POS_W-1:0]   rem_src;
    logic [POS_W-1:0]          rem_mag;
    logic                      rem_busy;
    logic [POS_W-1:0]          rem_val;
    logic [POS_W-1:0]          rem_fix;
    logic signed [POS_W:0]     wrap_d;
    logic signed [POS_W:0]     wrap_half;
    logic signed [POS_W+1:0]   span_w;
    logic signed [POS_W+1:0]   dist_next;
    logic signed [POS_W:0]     leg_diff;
    logic [POS_W:0]            leg_mag;
    logic [POS_W-1:0]          leg_count;
    logic                      out_free;

    // Configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_steps_reg     <= RST_ZERO_STEPS;
            steps_per_unit_reg <= RST_STEPS_PER_UNIT;
            min_value_reg      <= RST_MIN_VALUE;
            max_value_reg      <= RST_MAX_VALUE;
            default_span_reg   <= RST_DEFAULT_SPAN;
            circular_reg       <= 1'b0;
            backlash_reg       <= '0;
            step_delay_reg     <= RST_STEP_DELAY;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZERO_STEPS:     zero_steps_reg     <= cfg_data[GAIN_W-1:0];
                REG_STEPS_PER_UNIT: steps_per_unit_reg <= cfg_data[GAIN_W-1:0];
                REG_MIN_VALUE:      min_value_reg      <= cfg_data[VAL_W-1:0];
                REG_MAX_VALUE:      max_value_reg      <= cfg_data[VAL_W-1:0];
                REG_DEFAULT_SPAN:   default_span_reg   <= cfg_data[SHORT_W-1:0];
                REG_CIRCULAR:       circular_reg       <= cfg_data[0];
                REG_BACKLASH:       backlash_reg       <= cfg_data[SHORT_W-1:0];
                REG_STEP_DELAY:     step_delay_reg     <= cfg_data[SHORT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.take_in)
        begin
            op_reg    <= s_tuser;
            value_reg <= s_tdata[VAL_W-1:0];
            steps_reg <= s_tdata[VAL_W+POS_W-1:VAL_W];
        end
    end

    // Shared multiplier: gain times value offset, or |gain| times dial range
    assign spu_ext = MUL_A_W'(steps_per_unit_reg);
    assign zero_sh = {{(PROD_W-GAIN_W-FRAC_W){zero_steps_reg[GAIN_W-1]}},
                      zero_steps_reg, {FRAC_W{1'b0}}};

    always_comb
    begin
        if (cmd.span_sel)
        begin
            mul_a = spu_ext[MUL_A_W-1] ? -spu_ext : spu_ext;
            mul_b = DIFF_W'(max_value_reg) - DIFF_W'(min_value_reg);
        end
        else
        begin
            mul_a = spu_ext;
            mul_b = DIFF_W'(value_reg) - DIFF_W'(min_value_reg);
        end
    end

    assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

    // Rounding and span selection
    assign rnd_val   = round_q(acc_reg);
    assign dflt_span = (default_span_reg == '0) ? POS_W'(1) : POS_W'(default_span_reg);

    // Remainder unit operand and correction to a non-negative residue
    assign rem_src = cmd.rem_sel ? target_reg : needle_reg;
    assign rem_mag = rem_src[POS_W-1] ? POS_W'(~rem_src + POS_W'(1)) : POS_W'(rem_src);
    assign rem_fix = (rem_src[POS_W-1] && (rem_val != '0)) ? span_reg - rem_val : rem_val;

    sgp_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.rem_start),
        .dividend  (rem_mag),
        .divisor   (span_reg),
        .busy      (rem_busy),
        .remainder (rem_val)
    );

    // Shortest arc between the two residues
    assign wrap_d    = $signed({1'b0, tm_reg}) - $signed({1'b0, cm_reg});
    assign wrap_half = $signed({2'b00, span_reg[POS_W-1:1]});
    assign span_w    = $signed({2'b00, span_reg});

    always_comb
    begin
        if (wrap_d > wrap_half)
            dist_next = (POS_W+2)'(wrap_d) - span_w;
        else if (wrap_d < -wrap_half)
            dist_next = (POS_W+2)'(wrap_d) + span_w;
        else
            dist_next = (POS_W+2)'(wrap_d);
    end

    // Leg length and direction from the current position
    assign leg_diff  = (POS_W+1)'(leg_to_reg) - (POS_W+1)'(needle_reg);
    assign leg_mag   = leg_diff[POS_W] ? (POS_W+1)'(-leg_diff) : (POS_W+1)'(leg_diff);
    assign leg_count = leg_mag[POS_W] ? {POS_W{1'b1}} : leg_mag[POS_W-1:0];

    // Arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
            prod_reg <= mul_p;
        if (cmd.sum_en)
            acc_reg <= cmd.span_sel ? prod_reg : prod_reg + zero_sh;
        if (cmd.rnd_en)
        begin
            if (cmd.span_sel)
                span_reg <= (rnd_val > RND_W'(0)) ? rnd_val[POS_W-1:0] : dflt_span;
            else
                target_reg <= sat_pos(WIDE_W'(rnd_val));
        end
        if (cmd.cm_load)
            cm_reg <= rem_fix;
        if (cmd.tm_load)
            tm_reg <= rem_fix;
        if (cmd.wrap_en)
            dist_reg <= dist_next;
        if (cmd.wrap2_en)
            target_reg <= sat_pos(WIDE_W'(needle_reg) + WIDE_W'(dist_reg));
        if (cmd.plan_en)
        begin
            if (backlash_reg != '0)
                leg_to_reg <= sat_pos(WIDE_W'(target_reg) - WIDE_W'(backlash_reg));
            else
                leg_to_reg <= target_reg;
        end
        if (cmd.nudge_en)
            leg_to_reg <= sat_pos(WIDE_W'(needle_reg) + WIDE_W'(steps_reg));
        if (cmd.leg_to_target)
            leg_to_reg <= target_reg;
    end

    // Tracked needle position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            needle_reg <= '0;
        else if (cmd.load_pos)
            needle_reg <= steps_reg;
        else if (cmd.leg_emit)
            needle_reg <= leg_to_reg;
    end

    // Output register: holds one result until the downstream side takes it
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.leg_emit || cmd.coils_emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.leg_emit)
        begin
            out_count_reg <= leg_count;
            out_dir_reg   <= !leg_diff[POS_W];
            out_delay_reg <= step_delay_reg;
            out_coils_reg <= 1'b0;
            out_pos_reg   <= leg_to_reg;
            out_last_reg  <= 1'b0;
        end
        else if (cmd.coils_emit)
        begin
            out_count_reg <= '0;
            out_dir_reg   <= 1'b0;
            out_delay_reg <= '0;
            out_coils_reg <= 1'b1;
            out_pos_reg   <= needle_reg;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W-OUT_USED_W){1'b0}},
                       out_pos_reg, out_delay_reg, out_dir_reg, out_count_reg};
    assign m_tuser  = out_coils_reg;
    assign m_tlast  = out_last_reg;

    // Status towards the sequencer
    assign sts.op               = op_reg;
    assign sts.circular         = circular_reg;
    assign sts.backlash_nz      = backlash_reg != '0;
    assign sts.steps_zero       = steps_reg == '0;
    assign sts.target_eq_needle = target_reg == needle_reg;
    assign sts.leg_zero         = leg_diff == '0;
    assign sts.out_free         = out_free;
    assign sts.rem_done         = !rem_busy;

endmodule

@@ hdl/sgp_ctrl.sv @@
`timescale 1ns / 1ps

module sgp_ctrl
    import sgp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  sgp_status_t sts,
    output sgp_cmd_t    cmd
);

    sgp_state_t state_reg;
    sgp_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next-state logic
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                case (sts.op)
                    OP_SET_VALUE: state_next = ST_MUL_T;
                    OP_NUDGE:     state_next = sts.steps_zero ? ST_IDLE : ST_NUDGE;
                    default:      state_next = ST_IDLE;
                endcase
            end
            ST_MUL_T:  state_next = ST_SUM_T;
            ST_SUM_T:  state_next = ST_RND_T;
            ST_RND_T:  state_next = sts.circular ? ST_MUL_S : ST_PLAN;
            ST_MUL_S:  state_next = ST_SUM_S;
            ST_SUM_S:  state_next = ST_RND_S;
            ST_RND_S:  state_next = ST_REM_C;
            ST_REM_C:  state_next = ST_REM_CW;
            ST_REM_CW:
            begin
                if (sts.rem_done)
                    state_next = ST_REM_T;
            end
            ST_REM_T:  state_next = ST_REM_TW;
            ST_REM_TW:
            begin
                if (sts.rem_done)
                    state_next = ST_WRAP;
            end
            ST_WRAP:   state_next = ST_WRAP2;
            ST_WRAP2:  state_next = ST_PLAN;
            ST_PLAN:
            begin
                if (sts.backlash_nz)
                    state_next = ST_LEG1;
                else if (sts.target_eq_needle)
                    state_next = ST_IDLE;
                else
                    state_next = ST_LEG2;
            end
            ST_NUDGE:  state_next = ST_LEG2;
            ST_LEG1:
            begin
                if (sts.leg_zero || sts.out_free)
                    state_next = ST_LEG2;
            end
            ST_LEG2:
            begin
                if (sts.leg_zero || sts.out_free)
                    state_next = ST_COILS;
            end
            ST_COILS:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.take_in = s_tvalid;
            end
            ST_DECODE:
            begin
                cmd.load_pos = sts.op == OP_LOAD_POS;
            end
            ST_MUL_T:
            begin
                cmd.mul_en = 1'b1;
            end
            ST_SUM_T:
            begin
                cmd.sum_en = 1'b1;
            end
            ST_RND_T:
            begin
                cmd.rnd_en = 1'b1;
            end
            ST_MUL_S:
            begin
                cmd.span_sel = 1'b1;
                cmd.mul_en   = 1'b1;
            end
            ST_SUM_S:
            begin
                cmd.span_sel = 1'b1;
                cmd.sum_en   = 1'b1;
            end
            ST_RND_S:
            begin
                cmd.span_sel = 1'b1;
                cmd.rnd_en   = 1'b1;
            end
            ST_REM_C:
            begin
                cmd.rem_start = 1'b1;
            end
            ST_REM_CW:
            begin
                cmd.cm_load = sts.rem_done;
            end
            ST_REM_T:
            begin
                cmd.rem_sel   = 1'b1;
                cmd.rem_start = 1'b1;
            end
            ST_REM_TW:
            begin
                cmd.rem_sel = 1'b1;
                cmd.tm_load = sts.rem_done;
            end
            ST_WRAP:
            begin
                cmd.wrap_en = 1'b1;
            end
            ST_WRAP2:
            begin
                cmd.wrap2_en = 1'b1;
            end
            ST_PLAN:
            begin
                cmd.plan_en = 1'b1;
            end
            ST_NUDGE:
            begin
                cmd.nudge_en = 1'b1;
            end
            ST_LEG1:
            begin
                cmd.leg_emit      = !sts.leg_zero && sts.out_free;
                cmd.leg_to_target = sts.leg_zero || sts.out_free;
            end
            ST_LEG2:
            begin
                cmd.leg_emit = !sts.leg_zero && sts.out_free;
            end
            ST_COILS:
            begin
                cmd.coils_emit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
